@@ hw/rtl/bspd_pkg.sv @@
// Shared types and constants of the bitmap scanline pixel decoder.
// No dependencies; every other RTL file of the block refers to it by scoped names.
`default_nettype none

package bspd_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalAw          = $clog2(PaletteEntries);
  localparam int unsigned MaxWidth       = 16384;
  localparam int unsigned ColW           = 15;
  localparam int unsigned CntW           = 4;
  localparam int unsigned KW             = 3;

  localparam logic [ColW-1:0] WidthMax = ColW'(MaxWidth);

  // RLE8 escape codes (second byte after a zero count)
  localparam logic [7:0] EscEol   = 8'd0;
  localparam logic [7:0] EscEob   = 8'd1;
  localparam logic [7:0] EscDelta = 8'd2;

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_RLE8  = 3'd3,
    FMT_555   = 3'd4,
    FMT_565   = 3'd5,
    FMT_24BIT = 3'd6,
    FMT_32BIT = 3'd7
  } fmt_e;

  typedef enum logic [2:0] {
    RP_COUNT,
    RP_VALUE,
    RP_ESCAPE,
    RP_ABS,
    RP_PAD,
    RP_DX,
    RP_DY
  } rle_phase_e;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_idx_e;

  // One decoded input byte: up to eight results share it
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            from_pal;
    logic [7:0]      sel;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [7:0]      rep;
    logic            le;
    logic            ie;
    logic            err;
  } item_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] rep;
    logic       le;
    logic       ie;
    logic       err;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/bspd_palette.sv @@
// Palette memory: one write port, two read ports with registered read data.
// Depends on bspd_pkg for address width and depth.
`default_nettype none

module bspd_palette (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bspd_pkg::PalAw-1:0] waddr_i,
  input  logic [23:0]               wdata_i,
  input  logic                      re_i,
  input  logic [bspd_pkg::PalAw-1:0] raddr_a_i,
  input  logic [bspd_pkg::PalAw-1:0] raddr_b_i,
  output logic [23:0]               rdata_a_o,
  output logic [23:0]               rdata_b_o
);

  logic [23:0] mem [bspd_pkg::PaletteEntries];
  logic [23:0] rdata_a_q;
  logic [23:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ hw/rtl/bspd_step.sv @@
// Per-byte decode: configuration, scanline and RLE state, and the item descriptor.
// Depends on bspd_pkg for formats, RLE phases and the item_t descriptor.
`default_nettype none

module bspd_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       kind_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [bspd_pkg::ColW-1:0]  cfg_data_i,
  output bspd_pkg::item_t            item_o,
  output logic                       item_vld_o,
  output logic [bspd_pkg::PalAw-1:0] raddr_a_o,
  output logic [bspd_pkg::PalAw-1:0] raddr_b_o
);

  bspd_pkg::fmt_e             fmt_q, fmt_d;
  logic [bspd_pkg::ColW-1:0]  width_q, width_d;
  logic [bspd_pkg::ColW-1:0]  col_q, col_d;
  logic [1:0]                 bphase_q, bphase_d;
  logic [23:0]                asm_q, asm_d;
  logic [1:0]                 lphase_q, lphase_d;
  bspd_pkg::rle_phase_e       rphase_q, rphase_d;
  logic [7:0]                 rcount_q, rcount_d;
  logic                       odd_q, odd_d;

  logic                       col_lt_w;
  logic [bspd_pkg::ColW-1:0]  left;
  logic [bspd_pkg::ColW-1:0]  col_sum;
  logic [7:0]                 col_inc;
  logic [7:0]                 rep_rle;
  logic [7:0]                 rcount_dec;
  logic [1:0]                 lph_inc;
  logic [15:0]                v16;
  logic [4:0]                 r5;
  logic [4:0]                 b5;
  logic [7:0]                 g8;
  logic [bspd_pkg::ColW-1:0]  w_new;

  assign col_lt_w   = col_q < width_q;
  assign left       = col_lt_w ? (width_q - col_q) : '0;
  assign rep_rle    = (bspd_pkg::ColW'(rcount_q) < left) ? rcount_q : left[7:0];
  assign col_sum    = col_q + bspd_pkg::ColW'(col_inc);
  assign lph_inc    = lphase_q + 2'd1;
  assign rcount_dec = rcount_q - 8'd1;
  assign v16        = {data_byte_i, asm_q[7:0]};

  // Clamp the width write: zero acts as one, saturate at the maximum
  always_comb begin
    w_new = cfg_data_i;
    if (cfg_data_i == '0) begin
      w_new = bspd_pkg::ColW'(1);
    end else if (cfg_data_i > bspd_pkg::WidthMax) begin
      w_new = bspd_pkg::WidthMax;
    end
  end

  // 16-bit channel extraction with bit replication
  always_comb begin
    if (fmt_q == bspd_pkg::FMT_555) begin
      r5 = v16[14:10];
      g8 = {v16[9:5], v16[9:7]};
    end else begin
      r5 = v16[15:11];
      g8 = {v16[10:5], v16[10:9]};
    end
    b5 = v16[4:0];
  end

  // Palette read addresses
  always_comb begin
    unique case (fmt_q)
      bspd_pkg::FMT_1BPP: begin
        raddr_a_o = 8'd0;
        raddr_b_o = 8'd1;
      end
      bspd_pkg::FMT_4BPP: begin
        raddr_a_o = {4'd0, data_byte_i[7:4]};
        raddr_b_o = {4'd0, data_byte_i[3:0]};
      end
      default: begin
        raddr_a_o = data_byte_i;
        raddr_b_o = 8'd0;
      end
    endcase
  end

  // Column advance of this byte; in the raw formats it is also the pixel count
  always_comb begin
    col_inc = 8'd0;
    if (fmt_q == bspd_pkg::FMT_RLE8) begin
      if (rphase_q == bspd_pkg::RP_VALUE) begin
        col_inc = rep_rle;
      end else if (rphase_q == bspd_pkg::RP_ABS && left != '0) begin
        col_inc = 8'd1;
      end
    end else if (col_lt_w) begin
      unique case (fmt_q)
        bspd_pkg::FMT_1BPP:  col_inc = (left >= bspd_pkg::ColW'(8)) ? 8'd8 : {4'd0, left[3:0]};
        bspd_pkg::FMT_4BPP:  col_inc = (left >= bspd_pkg::ColW'(2)) ? 8'd2 : 8'd1;
        bspd_pkg::FMT_8BPP:  col_inc = 8'd1;
        bspd_pkg::FMT_555,
        bspd_pkg::FMT_565:   col_inc = (bphase_q != 2'd0) ? 8'd1 : 8'd0;
        bspd_pkg::FMT_24BIT: col_inc = (bphase_q == 2'd2) ? 8'd1 : 8'd0;
        bspd_pkg::FMT_32BIT: col_inc = (bphase_q == 2'd3) ? 8'd1 : 8'd0;
        default:             col_inc = 8'd0;
      endcase
    end
  end

  // Next state and item descriptor
  always_comb begin
    fmt_d      = fmt_q;
    width_d    = width_q;
    col_d      = col_q;
    bphase_d   = bphase_q;
    asm_d      = asm_q;
    lphase_d   = lphase_q;
    rphase_d   = rphase_q;
    rcount_d   = rcount_q;
    odd_d      = odd_q;
    item_o     = '0;
    item_vld_o = 1'b0;

    if (cfg_we_i) begin
      if (cfg_index_i == bspd_pkg::REG_WIDTH) begin
        width_d = w_new;
      end else begin
        fmt_d = bspd_pkg::fmt_e'(cfg_data_i[2:0]);
      end
      col_d    = '0;
      bphase_d = 2'd0;
      asm_d    = '0;
      lphase_d = 2'd0;
      rphase_d = bspd_pkg::RP_COUNT;
      rcount_d = 8'd0;
      odd_d    = 1'b0;
    end else if (accept_i && !kind_i) begin
      if (fmt_q == bspd_pkg::FMT_RLE8) begin
        col_d = col_sum;
        unique case (rphase_q)
          bspd_pkg::RP_COUNT: begin
            if (data_byte_i == 8'd0) begin
              rphase_d = bspd_pkg::RP_ESCAPE;
            end else begin
              rcount_d = data_byte_i;
              rphase_d = bspd_pkg::RP_VALUE;
            end
          end
          bspd_pkg::RP_VALUE: begin
            item_vld_o      = rep_rle != 8'd0;
            item_o.count    = bspd_pkg::CntW'(1);
            item_o.from_pal = 1'b1;
            item_o.rep      = rep_rle;
            rphase_d        = bspd_pkg::RP_COUNT;
          end
          bspd_pkg::RP_ESCAPE: begin
            if (data_byte_i == bspd_pkg::EscEol || data_byte_i == bspd_pkg::EscEob) begin
              item_vld_o   = 1'b1;
              item_o.count = bspd_pkg::CntW'(1);
              item_o.le    = 1'b1;
              item_o.ie    = data_byte_i == bspd_pkg::EscEob;
              col_d        = '0;
              rphase_d     = bspd_pkg::RP_COUNT;
            end else if (data_byte_i == bspd_pkg::EscDelta) begin
              item_vld_o   = 1'b1;
              item_o.count = bspd_pkg::CntW'(1);
              item_o.err   = 1'b1;
              rphase_d     = bspd_pkg::RP_DX;
            end else begin
              rcount_d = data_byte_i;
              odd_d    = data_byte_i[0];
              rphase_d = bspd_pkg::RP_ABS;
            end
          end
          bspd_pkg::RP_ABS: begin
            item_vld_o      = left != '0;
            item_o.count    = bspd_pkg::CntW'(1);
            item_o.from_pal = 1'b1;
            item_o.rep      = 8'd1;
            rcount_d        = rcount_dec;
            if (rcount_dec == 8'd0) begin
              rphase_d = odd_q ? bspd_pkg::RP_PAD : bspd_pkg::RP_COUNT;
            end
          end
          bspd_pkg::RP_DX: begin
            rphase_d = bspd_pkg::RP_DY;
          end
          default: begin
            rphase_d = bspd_pkg::RP_COUNT;
          end
        endcase
      end else if (!col_lt_w) begin
        // skip line padding up to the 4-byte boundary
        lphase_d = lph_inc;
        if (lph_inc == 2'd0) begin
          col_d = '0;
        end
      end else begin
        item_o.count = col_inc[bspd_pkg::CntW-1:0];
        item_o.rep   = 8'd1;
        item_vld_o   = col_inc != 8'd0;
        unique case (fmt_q)
          bspd_pkg::FMT_1BPP: begin
            item_o.from_pal = 1'b1;
            item_o.sel      = data_byte_i;
          end
          bspd_pkg::FMT_4BPP: begin
            item_o.from_pal = 1'b1;
            item_o.sel      = 8'h40;
          end
          bspd_pkg::FMT_555,
          bspd_pkg::FMT_565: begin
            item_o.red   = {r5, r5[4:2]};
            item_o.green = g8;
            item_o.blue  = {b5, b5[4:2]};
            item_o.alpha = 8'hFF;
            if (bphase_q == 2'd0) begin
              asm_d    = {16'd0, data_byte_i};
              bphase_d = 2'd1;
            end else begin
              asm_d    = '0;
              bphase_d = 2'd0;
            end
          end
          bspd_pkg::FMT_24BIT,
          bspd_pkg::FMT_32BIT: begin
            if (fmt_q == bspd_pkg::FMT_32BIT) begin
              item_o.red   = asm_q[23:16];
              item_o.alpha = data_byte_i;
            end else begin
              item_o.red   = data_byte_i;
              item_o.alpha = 8'hFF;
            end
            item_o.green = asm_q[15:8];
            item_o.blue  = asm_q[7:0];
            if (col_inc != 8'd0) begin
              asm_d    = '0;
              bphase_d = 2'd0;
            end else begin
              unique case (bphase_q)
                2'd0:    asm_d[7:0]   = data_byte_i;
                2'd1:    asm_d[15:8]  = data_byte_i;
                default: asm_d[23:16] = data_byte_i;
              endcase
              bphase_d = bphase_q + 2'd1;
            end
          end
          default: begin
            item_o.from_pal = 1'b1;
          end
        endcase
        item_o.le = (col_inc != 8'd0) && (col_sum >= width_q);
        col_d     = col_sum;
        lphase_d  = lph_inc;
        if (col_sum >= width_q && lph_inc == 2'd0) begin
          col_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= bspd_pkg::FMT_24BIT;
      width_q  <= bspd_pkg::ColW'(1);
      col_q    <= '0;
      bphase_q <= 2'd0;
      asm_q    <= '0;
      lphase_q <= 2'd0;
      rphase_q <= bspd_pkg::RP_COUNT;
      rcount_q <= 8'd0;
      odd_q    <= 1'b0;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      col_q    <= col_d;
      bphase_q <= bphase_d;
      asm_q    <= asm_d;
      lphase_q <= lphase_d;
      rphase_q <= rphase_d;
      rcount_q <= rcount_d;
      odd_q    <= odd_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bspd_expand.sv @@
// Result expansion: holds one decoded item and issues its results into the output register.
// Depends on bspd_pkg for item_t and res_t.
`default_nettype none

module bspd_expand (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bspd_pkg::item_t  item_i,
  input  logic [23:0]      rd_a_i,
  input  logic [23:0]      rd_b_i,
  input  logic             out_ready_i,
  output logic             take_o,
  output logic             out_valid_o,
  output bspd_pkg::res_t   res_o
);

  logic                       a_vld_q, a_vld_d;
  bspd_pkg::item_t            a_q;
  logic [bspd_pkg::KW-1:0]    k_q, k_d;
  logic                       a_adv;
  logic                       a_last;
  logic [bspd_pkg::CntW-1:0]  cnt_m1;
  logic                       pick;
  logic [23:0]                color;
  bspd_pkg::res_t             res_d;
  bspd_pkg::res_t             res_q;
  logic                       b_vld_q, b_vld_d;

  assign a_adv  = a_vld_q && (!b_vld_q || out_ready_i);
  assign cnt_m1 = a_q.count - bspd_pkg::CntW'(1);
  assign a_last = {1'b0, k_q} == cnt_m1;
  assign take_o = !a_vld_q || (a_adv && a_last);

  // Pixel k of a palette item takes entry B when its select bit is set
  assign pick  = a_q.sel[3'd7 - k_q];
  assign color = pick ? rd_b_i : rd_a_i;

  always_comb begin
    res_d.red   = a_q.from_pal ? color[23:16] : a_q.red;
    res_d.green = a_q.from_pal ? color[15:8]  : a_q.green;
    res_d.blue  = a_q.from_pal ? color[7:0]   : a_q.blue;
    res_d.alpha = a_q.from_pal ? 8'hFF        : a_q.alpha;
    res_d.rep   = a_q.rep;
    res_d.le    = a_q.le && a_last;
    res_d.ie    = a_q.ie;
    res_d.err   = a_q.err;
    res_d.last  = a_last;
  end

  always_comb begin
    a_vld_d = a_vld_q;
    k_d     = k_q;
    if (load_i) begin
      a_vld_d = 1'b1;
      k_d     = '0;
    end else if (a_adv) begin
      if (a_last) begin
        a_vld_d = 1'b0;
      end else begin
        k_d = k_q + bspd_pkg::KW'(1);
      end
    end
    b_vld_d = a_adv || (b_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      k_q     <= '0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      k_q     <= k_d;
      b_vld_q <= b_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= item_i;
    end
    if (a_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_scanline_pixel_decoder.sv @@
// Bitmap scanline pixel decoder: byte stream in, RGBA pixel results out.
// Depends on bspd_pkg, bspd_palette, bspd_step and bspd_expand.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o): each transfer carries either a pixel data
//   byte (kind_i = 0) or a palette write (kind_i = 1, palette_index_i, palette_color_i).
//   Load the palette before pixel bytes that index it.
//   Output channel (out_valid_o / out_ready_i): one result per transfer. repeat_res_o of
//   zero marks an RLE escape marker (end of line, end of bitmap, delta error); last_o
//   flags the final result produced by a byte.
//   Configuration channel (cfg_valid_i / cfg_ready_o): always ready; index 0 selects
//   the pixel format, index 1 the image width. Any write restarts the scanline.
//   Write configuration only while the block is idle.
// Timing:
//   A byte is accepted one per cycle as long as it yields at most one result and the
//   output is not stalled. A 1bpp byte yields up to eight pixels; the next byte is taken
//   only as the last of them moves into the output register. The item and its palette
//   data register at the byte's transfer edge and the output register after that; the
//   output register holds while out_ready_i is low. Bytes with no result (palette writes,
//   partial 16/24/32-bit pixels, line padding, RLE count bytes) load no item.
// Reset: clears all scanline state; format is 24-bit, width is 1. Palette contents are
//   left as they are and must be written before use.
// Stall: while the receiver holds out_ready_i low the output register keeps its result;
//   one more byte can still be taken into the decode stage behind it.
`default_nettype none

module bitmap_scanline_pixel_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // pixel byte / palette input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [7:0]                 palette_index_i,
  input  logic [23:0]                palette_color_i,
  // pixel results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [7:0]                 alpha_o,
  output logic [7:0]                 repeat_res_o,
  output logic                       line_end_o,
  output logic                       image_end_o,
  output logic                       error_o,
  output logic                       last_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [bspd_pkg::ColW-1:0]  cfg_data_i
);

  logic                       take;
  logic                       accept;
  bspd_pkg::item_t            item;
  logic                       item_vld;
  logic [bspd_pkg::PalAw-1:0] raddr_a;
  logic [bspd_pkg::PalAw-1:0] raddr_b;
  logic [23:0]                rd_a;
  logic [23:0]                rd_b;
  bspd_pkg::res_t             res;

  assign in_ready_o  = take;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && take;

  // Decode the byte against scanline/RLE state; issue palette reads in the same cycle
  bspd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_o      (item),
    .item_vld_o  (item_vld),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b)
  );

  // Palette writes and reads happen at the transfer edge; data lines up with the item
  bspd_palette u_palette (
    .clk_i     (clk_i),
    .we_i      (accept && kind_i),
    .waddr_i   (palette_index_i),
    .wdata_i   (palette_color_i),
    .re_i      (accept && !kind_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Hold the item and hand its results one at a time to the output register
  bspd_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && item_vld),
    .item_i      (item),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .out_ready_i (out_ready_i),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign red_o        = res.red;
  assign green_o      = res.green;
  assign blue_o       = res.blue;
  assign alpha_o      = res.alpha;
  assign repeat_res_o = res.rep;
  assign line_end_o   = res.le;
  assign image_end_o  = res.ie;
  assign error_o      = res.err;
  assign last_o       = res.last;

  // End-of-bitmap marker is a pure marker that closes the line and the byte
  a_eob_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_end_o) |-> (line_end_o && last_o && repeat_res_o == 8'd0))
    else $error("end-of-bitmap result is not a closing marker");

  // Delta error marker carries no pixel and does not close the line
  a_err_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (!line_end_o && last_o && repeat_res_o == 8'd0))
    else $error("delta error result is malformed");

  // A stalled mid-byte result means the rest of that byte still occupies the decode stage
  a_busy_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a byte is still being expanded");

endmodule

`default_nettype wire
